// File: hdl/postfix_stream_evaluator_unit_defines.svh
// ----------------------------------------------------------------------------
// Postfix stream evaluator assertion macros
// Shared concurrent assertion forms used by the evaluator's RTL.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STREAM_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_STREAM_EVALUATOR_UNIT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define PSE_ASSERT_ALWAYS(label, clk_s, rst_s, expr, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define PSE_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pse_pkg.sv
// ----------------------------------------------------------------------------
// Postfix stream evaluator package
// Defaults, character and status codes, unit opcodes and shared types.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 48;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int WHOLE_W   = 32;
    localparam int FRACACC_W = 20;
    localparam int FDIG_W    = 3;
    localparam logic [FDIG_W-1:0] FRAC_DIGITS_MAX = 3'd6;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNDER    = 3'd1;
    localparam logic [2:0] ST_BADCHAR  = 3'd2;
    localparam logic [2:0] ST_DIVZERO  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_SAT      = 3'd5;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_CONV = 3'd4;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic sat;
        logic dz;
    } alu_rsp_t;

    // Keeps the first error of an expression.
    function automatic logic [2:0] raise_err(input logic [2:0] cur, input logic [2:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    function automatic logic [FRACACC_W-1:0] pow10(input logic [FDIG_W-1:0] n);
        logic [FRACACC_W-1:0] r;
        unique case (n)
            3'd1:    r = 20'd10;
            3'd2:    r = 20'd100;
            3'd3:    r = 20'd1000;
            3'd4:    r = 20'd10000;
            3'd5:    r = 20'd100000;
            3'd6:    r = 20'd1000000;
            default: r = 20'd1;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/pse_in_if.sv
// ----------------------------------------------------------------------------
// Postfix stream evaluator input channel
// Carries one character of the expression per transfer.
// ----------------------------------------------------------------------------
interface pse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       final_req;

    modport source (output valid, output symbol, output final_req, input ready);
    modport sink (input valid, input symbol, input final_req, output ready);
endinterface

// File: hdl/pse_out_if.sv
// ----------------------------------------------------------------------------
// Postfix stream evaluator output channel
// Carries the final value and status of one expression per transfer.
// ----------------------------------------------------------------------------
interface pse_out_if #(
    parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] answer;
    logic [2:0]                    status;

    modport source (output valid, output answer, output status, input ready);
    modport sink (input valid, input answer, input status, output ready);
endinterface

// File: hdl/postfix_stream_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Postfix stream evaluator
// Parses a postfix expression one character per transfer and evaluates it
// in saturating signed fixed point on a stack, returning the top value and
// a sticky status on the last character.
//
//   channel  | dir | payload            | transfer when
//   in_ch    | in  | symbol, final_req  | valid && ready
//   out_ch   | out | answer, status     | valid && ready
//
// A plain character passes from acceptance through the minus check, the
// decode and the end check back to waiting. Closing an open number runs the
// bit-serial divide of the conversion. An operator adds the close check, the
// two stack reads and the start, then the add or subtract, the bit-serial
// multiply or the bit-serial divide. The last character adds the close of
// any open number, any final operator and the read of the top value.
// in_ch.ready is high only while the sequencer waits for a character.
// A pending result waits in the output register; a second one waits in S_OUT2.
// Reset clears all control state; the stack memory needs no clearing.
// ----------------------------------------------------------------------------
`include "postfix_stream_evaluator_unit_defines.svh"

module postfix_stream_evaluator_unit #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = pse_pkg::FRAC_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    pse_in_if.sink    in_ch,
    pse_out_if.source out_ch
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PM        = 4'd1;
    localparam logic [3:0] S_MAIN      = 4'd2;
    localparam logic [3:0] S_END       = 4'd3;
    localparam logic [3:0] S_CLOSE     = 4'd4;
    localparam logic [3:0] S_CONV_WAIT = 4'd5;
    localparam logic [3:0] S_POSTCLOSE = 4'd6;
    localparam logic [3:0] S_OPCHK     = 4'd7;
    localparam logic [3:0] S_RDB       = 4'd8;
    localparam logic [3:0] S_RDA       = 4'd9;
    localparam logic [3:0] S_OPWAIT    = 4'd10;
    localparam logic [3:0] S_OUT       = 4'd11;
    localparam logic [3:0] S_OUT2      = 4'd12;

    localparam logic [1:0] PH_PRE  = 2'd0;
    localparam logic [1:0] PH_MAIN = 2'd1;
    localparam logic [1:0] PH_FIN  = 2'd2;

    logic [3:0]                     state_reg, state_next;
    logic [1:0]                     phase_reg, phase_next;
    logic [7:0]                     sym_reg, sym_next;
    logic                           fin_reg, fin_next;
    logic                           op_pend_reg, op_pend_next;
    logic [2:0]                     op_reg, op_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [pse_pkg::WHOLE_W-1:0]    whole_reg, whole_next;
    logic [pse_pkg::FRACACC_W-1:0]  frac_reg, frac_next;
    logic [pse_pkg::FDIG_W-1:0]     fdig_reg, fdig_next;
    logic                           open_reg, open_next;
    logic                           neg_reg, neg_next;
    logic                           dot_reg, dot_next;
    logic                           stop_reg, stop_next;
    logic                           pm_reg, pm_next;
    logic [2:0]                     err_reg, err_next;
    logic [VALUE_WIDTH-1:0]         b_reg, b_next;
    logic                           ov_reg, ov_next;
    logic [VALUE_WIDTH-1:0]         ans_reg, ans_next;
    logic [2:0]                     sts_reg, sts_next;

    logic                   is_space, is_digit, is_letter;
    logic [3:0]             dg;
    logic [35:0]            whole_t;
    logic [23:0]            frac_t;
    logic [CW-1:0]          cnt_m1, cnt_m2;
    logic                   full;
    logic [3:0]             route_state;
    logic                   we, re;
    logic [AW-1:0]          waddr, raddr;
    logic [VALUE_WIDTH-1:0] wdata, rdata;
    pse_pkg::alu_req_t      alu_req;
    pse_pkg::alu_rsp_t      alu_rsp;
    logic [VALUE_WIDTH-1:0] alu_result;

    pse_stack #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    pse_alu #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (rdata),
        .b      (b_reg),
        .whole  (whole_reg),
        .frac   (frac_reg),
        .fdig   (fdig_reg),
        .neg    (neg_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_MAIN;
            op_pend_reg <= 1'b0;
            cnt_reg     <= '0;
            whole_reg   <= '0;
            frac_reg    <= '0;
            fdig_reg    <= '0;
            open_reg    <= 1'b0;
            neg_reg     <= 1'b0;
            dot_reg     <= 1'b0;
            stop_reg    <= 1'b0;
            pm_reg      <= 1'b0;
            err_reg     <= pse_pkg::ST_OK;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            op_pend_reg <= op_pend_next;
            cnt_reg     <= cnt_next;
            whole_reg   <= whole_next;
            frac_reg    <= frac_next;
            fdig_reg    <= fdig_next;
            open_reg    <= open_next;
            neg_reg     <= neg_next;
            dot_reg     <= dot_next;
            stop_reg    <= stop_next;
            pm_reg      <= pm_next;
            err_reg     <= err_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        fin_reg <= fin_next;
        op_reg  <= op_next;
        b_reg   <= b_next;
        ans_reg <= ans_next;
        sts_reg <= sts_next;
    end

    assign is_space  = (sym_reg == pse_pkg::CH_SPACE);
    assign is_digit  = (sym_reg >= pse_pkg::CH_ZERO) && (sym_reg <= pse_pkg::CH_NINE);
    assign is_letter = ((sym_reg >= pse_pkg::CH_UP_A) && (sym_reg <= pse_pkg::CH_UP_Z))
                    || ((sym_reg >= pse_pkg::CH_LO_A) && (sym_reg <= pse_pkg::CH_LO_Z));
    assign dg        = sym_reg[3:0];

    // Times ten by shift and add; the whole part sticks at all ones.
    assign whole_t = ({4'b0000, whole_reg} << 3) + ({4'b0000, whole_reg} << 1) + 36'(dg);
    assign frac_t  = ({4'b0000, frac_reg} << 3) + ({4'b0000, frac_reg} << 1) + 24'(dg);

    assign cnt_m1 = cnt_reg - CW'(1);
    assign cnt_m2 = cnt_reg - CW'(2);
    assign full   = (cnt_reg >= CW'(STACK_DEPTH));

    // Where the sequencer continues once an operator or token close is done.
    assign route_state = (phase_reg == PH_PRE) ? S_MAIN
                       : (phase_reg == PH_FIN) ? S_OUT : S_END;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        sym_next     = sym_reg;
        fin_next     = fin_reg;
        op_pend_next = op_pend_reg;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        whole_next   = whole_reg;
        frac_next    = frac_reg;
        fdig_next    = fdig_reg;
        open_next    = open_reg;
        neg_next     = neg_reg;
        dot_next     = dot_reg;
        stop_next    = stop_reg;
        pm_next      = pm_reg;
        err_next     = err_reg;
        b_next       = b_reg;
        ov_next      = ov_reg;
        ans_next     = ans_reg;
        sts_next     = sts_reg;
        we           = 1'b0;
        waddr        = cnt_reg[AW-1:0];
        wdata        = alu_result;
        re           = 1'b0;
        raddr        = cnt_m1[AW-1:0];
        alu_req      = '0;

        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    sym_next   = in_ch.symbol;
                    fin_next   = in_ch.final_req;
                    state_next = S_PM;
                end
            end
            S_PM:
            begin
                state_next = S_MAIN;
                if (pm_reg)
                begin
                    pm_next = 1'b0;
                    if (is_space)
                    begin
                        op_next      = pse_pkg::OP_SUB;
                        op_pend_next = 1'b1;
                        phase_next   = PH_PRE;
                        state_next   = S_CLOSE;
                    end
                    else if (!open_reg)
                    begin
                        open_next = 1'b1;
                        neg_next  = 1'b1;
                        dot_next  = 1'b0;
                        stop_next = 1'b0;
                    end
                    else
                    begin
                        stop_next = 1'b1;
                    end
                end
            end
            S_MAIN:
            begin
                phase_next = PH_MAIN;
                state_next = S_END;
                if (is_space)
                begin
                    op_pend_next = 1'b0;
                    state_next   = S_CLOSE;
                end
                else if ((sym_reg == pse_pkg::CH_PLUS) || (sym_reg == pse_pkg::CH_STAR)
                         || (sym_reg == pse_pkg::CH_SLASH)
                         || ((sym_reg == pse_pkg::CH_MINUS) && fin_reg))
                begin
                    op_pend_next = 1'b1;
                    state_next   = S_CLOSE;
                    if (sym_reg == pse_pkg::CH_PLUS)
                    begin
                        op_next = pse_pkg::OP_ADD;
                    end
                    else if (sym_reg == pse_pkg::CH_STAR)
                    begin
                        op_next = pse_pkg::OP_MUL;
                    end
                    else if (sym_reg == pse_pkg::CH_SLASH)
                    begin
                        op_next = pse_pkg::OP_DIV;
                    end
                    else
                    begin
                        op_next = pse_pkg::OP_SUB;
                    end
                end
                else if (sym_reg == pse_pkg::CH_MINUS)
                begin
                    pm_next = 1'b1;
                end
                else if (is_digit)
                begin
                    open_next = 1'b1;
                    if (!stop_reg)
                    begin
                        if (!dot_reg)
                        begin
                            whole_next = (|whole_t[35:32]) ? '1 : whole_t[31:0];
                        end
                        else if (fdig_reg < pse_pkg::FRAC_DIGITS_MAX)
                        begin
                            frac_next = frac_t[pse_pkg::FRACACC_W-1:0];
                            fdig_next = fdig_reg + pse_pkg::FDIG_W'(1);
                        end
                    end
                end
                else if (sym_reg == pse_pkg::CH_POINT)
                begin
                    open_next = 1'b1;
                    if (dot_reg)
                    begin
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        dot_next = 1'b1;
                    end
                end
                else if (is_letter)
                begin
                    open_next = 1'b1;
                    stop_next = 1'b1;
                    err_next  = pse_pkg::raise_err(err_reg, pse_pkg::ST_BADCHAR);
                end
                else
                begin
                    err_next = pse_pkg::raise_err(err_reg, pse_pkg::ST_BADCHAR);
                end
            end
            S_END:
            begin
                if (fin_reg)
                begin
                    phase_next   = PH_FIN;
                    op_pend_next = 1'b0;
                    state_next   = S_CLOSE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLOSE:
            begin
                if (open_reg)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = pse_pkg::OP_CONV;
                    state_next    = S_CONV_WAIT;
                end
                else
                begin
                    state_next = S_POSTCLOSE;
                end
            end
            S_CONV_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    err_next = pse_pkg::raise_err(
                        pse_pkg::raise_err(err_reg,
                            alu_rsp.sat ? pse_pkg::ST_SAT : pse_pkg::ST_OK),
                        full ? pse_pkg::ST_OVERFLOW : pse_pkg::ST_OK);
                    if (!full)
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    whole_next = '0;
                    frac_next  = '0;
                    fdig_next  = '0;
                    open_next  = 1'b0;
                    neg_next   = 1'b0;
                    dot_next   = 1'b0;
                    stop_next  = 1'b0;
                    state_next = S_POSTCLOSE;
                end
            end
            S_POSTCLOSE:
            begin
                state_next = op_pend_reg ? S_OPCHK : route_state;
            end
            S_OPCHK:
            begin
                if (cnt_reg < CW'(2))
                begin
                    err_next     = pse_pkg::raise_err(err_reg, pse_pkg::ST_UNDER);
                    op_pend_next = 1'b0;
                    state_next   = route_state;
                end
                else
                begin
                    re         = 1'b1;
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                // The right operand arrives first, then the left one is read.
                b_next     = rdata;
                re         = 1'b1;
                raddr      = cnt_m2[AW-1:0];
                state_next = S_RDA;
            end
            S_RDA:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = op_reg;
                state_next    = S_OPWAIT;
            end
            S_OPWAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.dz)
                    begin
                        err_next = pse_pkg::raise_err(err_reg, pse_pkg::ST_DIVZERO);
                    end
                    else if (alu_rsp.sat)
                    begin
                        err_next = pse_pkg::raise_err(err_reg, pse_pkg::ST_SAT);
                    end
                    we           = 1'b1;
                    waddr        = cnt_m2[AW-1:0];
                    cnt_next     = cnt_m1;
                    op_pend_next = 1'b0;
                    state_next   = route_state;
                end
            end
            S_OUT:
            begin
                re         = 1'b1;
                state_next = S_OUT2;
            end
            S_OUT2:
            begin
                if (!ov_reg)
                begin
                    ans_next   = (cnt_reg == '0) ? '0 : rdata;
                    sts_next   = pse_pkg::raise_err(err_reg,
                        (cnt_reg == '0) ? pse_pkg::ST_UNDER : pse_pkg::ST_OK);
                    ov_next    = 1'b1;
                    cnt_next   = '0;
                    whole_next = '0;
                    frac_next  = '0;
                    fdig_next  = '0;
                    open_next  = 1'b0;
                    neg_next   = 1'b0;
                    dot_next   = 1'b0;
                    stop_next  = 1'b0;
                    pm_next    = 1'b0;
                    err_next   = pse_pkg::ST_OK;
                    phase_next = PH_MAIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = ov_reg;
    assign out_ch.answer = ans_reg;
    assign out_ch.status = sts_reg;

    `PSE_ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_reg <= CW'(STACK_DEPTH), "stack count beyond depth")
    `PSE_ASSERT_IMPLY(a_alu_done_wait, clk, rst_n, alu_rsp.done, (state_reg == S_CONV_WAIT) || (state_reg == S_OPWAIT), "arithmetic result with no waiting sequencer")
    `PSE_ASSERT_NEXT(a_out_clears, clk, rst_n, (state_reg == S_OUT2) && !ov_reg, (cnt_reg == '0) && ov_reg && (err_reg == pse_pkg::ST_OK), "expression state not cleared after result")

endmodule

// File: hdl/pse_stack.sv
// ----------------------------------------------------------------------------
// Postfix stream evaluator value stack
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module pse_stack #(
    parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = pse_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/pse_alu.sv
// ----------------------------------------------------------------------------
// Postfix stream evaluator arithmetic unit
// Shared add/subtract datapath stepped for multiply, divide and number
// conversion, with saturation to the signed fixed-point range.
// ----------------------------------------------------------------------------
module pse_alu #(
    parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = pse_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pse_pkg::alu_req_t                   req,
    input  logic signed [VALUE_WIDTH-1:0]       a,
    input  logic signed [VALUE_WIDTH-1:0]       b,
    input  logic [pse_pkg::WHOLE_W-1:0]         whole,
    input  logic [pse_pkg::FRACACC_W-1:0]       frac,
    input  logic [pse_pkg::FDIG_W-1:0]          fdig,
    input  logic                                neg,
    output pse_pkg::alu_rsp_t                   rsp,
    output logic signed [VALUE_WIDTH-1:0]       result
);

    localparam int MW = (VALUE_WIDTH > 22) ? VALUE_WIDTH : 22;
    localparam int NW = MW + FRAC_BITS;
    localparam int PW = 2 * MW + FRAC_BITS;
    localparam int KW = $clog2(NW + 1);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_ITER = 2'd1;
    localparam logic [1:0] A_SUM  = 2'd2;
    localparam logic [1:0] A_PACK = 2'd3;

    localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [1:0]                    state_reg, state_next;
    logic [2:0]                    op_reg, op_next;
    logic [KW-1:0]                 cnt_reg, cnt_next;
    logic                          neg_reg, neg_next;
    logic                          dz_reg, dz_next;
    logic [VALUE_WIDTH-1:0]        a_reg, a_next;
    logic [VALUE_WIDTH-1:0]        b_reg, b_next;
    logic [pse_pkg::WHOLE_W-1:0]   whole_reg, whole_next;
    logic [MW-1:0]                 opnd_reg, opnd_next;
    logic [MW:0]                   hi_reg, hi_next;
    logic [NW-1:0]                 lo_reg, lo_next;
    logic [PW-1:0]                 mag_reg, mag_next;

    logic [VALUE_WIDTH-1:0] mag_a, mag_b;
    logic [MW:0]            add_in;
    logic [MW:0]            add_sum;
    logic [MW+1:0]          sub_diff;
    logic                   ge;
    logic [MW:0]            mul_hi;
    logic [2*MW-1:0]        prod;
    logic [VALUE_WIDTH:0]   as_sum;
    logic                   hi_nz;
    logic                   pack_sat;
    logic [VALUE_WIDTH-1:0] pack_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        dz_reg    <= dz_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        whole_reg <= whole_next;
        opnd_reg  <= opnd_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mag_reg   <= mag_next;
    end

    assign mag_a = a[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - a) : a;
    assign mag_b = b[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - b) : b;

    // The iteration datapath: multiply adds the multiplicand into the upper product,
    // divide and conversion trial-subtract the divisor from the shifted remainder.
    assign add_in   = (op_reg == pse_pkg::OP_MUL) ? {1'b0, hi_reg[MW-1:0]}
                                                  : {hi_reg[MW-1:0], lo_reg[NW-1]};
    assign add_sum  = add_in + {1'b0, opnd_reg};
    assign sub_diff = {1'b0, add_in} - {2'b00, opnd_reg};
    assign ge       = !sub_diff[MW+1];
    assign mul_hi   = lo_reg[0] ? add_sum : add_in;
    assign prod     = {hi_reg[MW-1:0], lo_reg[MW-1:0]};

    assign as_sum = (op_reg == pse_pkg::OP_SUB)
                  ? ({a_reg[VALUE_WIDTH-1], a_reg} - {b_reg[VALUE_WIDTH-1], b_reg})
                  : ({a_reg[VALUE_WIDTH-1], a_reg} + {b_reg[VALUE_WIDTH-1], b_reg});

    assign hi_nz = |mag_reg[PW-1:VALUE_WIDTH];

    always_comb
    begin
        pack_sat = 1'b0;
        pack_val = '0;
        if ((op_reg == pse_pkg::OP_ADD) || (op_reg == pse_pkg::OP_SUB))
        begin
            pack_sat = as_sum[VALUE_WIDTH] ^ as_sum[VALUE_WIDTH-1];
            if (pack_sat)
            begin
                pack_val = as_sum[VALUE_WIDTH] ? VMIN : VMAX;
            end
            else
            begin
                pack_val = as_sum[VALUE_WIDTH-1:0];
            end
        end
        else if (dz_reg)
        begin
            pack_val = a_reg[VALUE_WIDTH-1] ? VMIN : VMAX;
        end
        else if (neg_reg)
        begin
            pack_sat = hi_nz || (mag_reg[VALUE_WIDTH-1] && (|mag_reg[VALUE_WIDTH-2:0]));
            pack_val = pack_sat ? VMIN : (VALUE_WIDTH'(0) - mag_reg[VALUE_WIDTH-1:0]);
        end
        else
        begin
            pack_sat = hi_nz || mag_reg[VALUE_WIDTH-1];
            pack_val = pack_sat ? VMAX : mag_reg[VALUE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        dz_next    = dz_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        whole_next = whole_reg;
        opnd_next  = opnd_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mag_next   = mag_reg;

        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    a_next     = a;
                    b_next     = b;
                    whole_next = whole;
                    dz_next    = 1'b0;
                    hi_next    = '0;
                    neg_next   = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
                    unique case (req.op)
                        pse_pkg::OP_MUL:
                        begin
                            opnd_next  = MW'(mag_a);
                            lo_next    = NW'(mag_b);
                            cnt_next   = KW'(MW);
                            state_next = A_ITER;
                        end
                        pse_pkg::OP_DIV:
                        begin
                            opnd_next = MW'(mag_b);
                            lo_next   = NW'(mag_a) << FRAC_BITS;
                            cnt_next  = KW'(NW);
                            if (b == '0)
                            begin
                                dz_next    = 1'b1;
                                state_next = A_PACK;
                            end
                            else
                            begin
                                state_next = A_ITER;
                            end
                        end
                        pse_pkg::OP_CONV:
                        begin
                            neg_next   = neg;
                            opnd_next  = MW'(pse_pkg::pow10(fdig));
                            lo_next    = (NW'(frac) << FRAC_BITS)
                                       + NW'(pse_pkg::pow10(fdig) >> 1);
                            cnt_next   = KW'(NW);
                            state_next = A_ITER;
                        end
                        default:
                        begin
                            state_next = A_PACK;
                        end
                    endcase
                end
            end
            A_ITER:
            begin
                if (op_reg == pse_pkg::OP_MUL)
                begin
                    hi_next            = {1'b0, mul_hi[MW:1]};
                    lo_next[MW-1:0]    = {mul_hi[0], lo_reg[MW-1:1]};
                end
                else
                begin
                    hi_next = ge ? sub_diff[MW:0] : add_in;
                    lo_next = {lo_reg[NW-2:0], ge};
                end
                cnt_next = cnt_reg - KW'(1);
                if (cnt_reg == KW'(1))
                begin
                    state_next = A_SUM;
                end
            end
            A_SUM:
            begin
                if (op_reg == pse_pkg::OP_MUL)
                begin
                    mag_next = PW'(prod >> FRAC_BITS);
                end
                else if (op_reg == pse_pkg::OP_CONV)
                begin
                    mag_next = (PW'(whole_reg) << FRAC_BITS) + PW'(lo_reg);
                end
                else
                begin
                    mag_next = PW'(lo_reg);
                end
                state_next = A_PACK;
            end
            A_PACK:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    assign rsp.done = (state_reg == A_PACK);
    assign rsp.sat  = (state_reg == A_PACK) && pack_sat;
    assign rsp.dz   = (state_reg == A_PACK) && dz_reg
                    && (op_reg == pse_pkg::OP_DIV);
    assign result   = pack_val;

endmodule
